// ===== rtl/tape_machine_instruction_executor_macros.svh =====
// Assertion macros used by the top level of the tape machine executor
`ifndef TAPE_MACHINE_INSTRUCTION_EXECUTOR_MACROS_SVH
`define TAPE_MACHINE_INSTRUCTION_EXECUTOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TME_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define TME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tme_pkg.sv =====
// Package: types, constants and opcodes of the tape machine executor
`timescale 1ns / 1ps

package tme_pkg;

   localparam int TAPE_DEPTH = 4096;
   localparam int PROG_DEPTH = 65536;

   localparam int DP_W   = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
   localparam int PC_W   = 17;
   localparam int LEN_W  = 17;
   localparam int ARG_W  = 16;
   localparam int MODE_W = 4;
   localparam int BYTE_W = 8;

   typedef enum logic [MODE_W-1:0] {
      OP_PTR_INC = 4'd0,
      OP_PTR_DEC = 4'd1,
      OP_ADD     = 4'd2,
      OP_SUB     = 4'd3,
      OP_OUT     = 4'd4,
      OP_IN      = 4'd5,
      OP_JFZ     = 4'd6,
      OP_JBZ     = 4'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_INVALID    = 2'd1,
      ST_TERMINATED = 2'd2,
      ST_SEGFAULT   = 2'd3
   } status_type;

   // Outcome of executing one instruction
   typedef struct packed {
      status_type              status;
      logic [PC_W-1:0]         next_pc;
      logic                    out_valid;
      logic [BYTE_W-1:0]       out_byte;
      logic [DP_W-1:0]         dp_next;
      logic                    cell_we;
      logic [BYTE_W-1:0]       cell_wdata;
   } exec_result_type;

endpackage

// ===== rtl/tme_tape_ram.sv =====
// Tape memory: one write port, one registered read port
`timescale 1ns / 1ps

module tme_tape_ram (
   input  logic                       clock,
   input  logic                       we,
   input  logic [tme_pkg::DP_W-1:0]   waddr,
   input  logic [tme_pkg::BYTE_W-1:0] wdata,
   input  logic [tme_pkg::DP_W-1:0]   raddr,
   output logic [tme_pkg::BYTE_W-1:0] rdata
);
   import tme_pkg::*;

   logic [BYTE_W-1:0] mem [TAPE_DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tme_exec.sv =====
// Execute logic: one instruction against pc, data pointer and current cell
`timescale 1ns / 1ps

module tme_exec (
   input  logic [tme_pkg::PC_W-1:0]     pc,
   input  logic [tme_pkg::DP_W-1:0]     dp,
   input  logic [tme_pkg::LEN_W-1:0]    prog_len,
   input  logic [tme_pkg::MODE_W-1:0]   mode,
   input  logic [tme_pkg::ARG_W-1:0]    instr_arg,
   input  logic [tme_pkg::BYTE_W-1:0]   input_byte,
   input  logic [tme_pkg::BYTE_W-1:0]   cur_cell,
   output tme_pkg::exec_result_type     res
);
   import tme_pkg::*;

   op_type           op;
   logic [PC_W-1:0]  dp_x;
   logic [PC_W-1:0]  arg_x;
   logic [PC_W-1:0]  tape_room;
   logic [PC_W-1:0]  prog_room;
   logic             cell_zero;

   assign op        = op_type'(mode);
   assign dp_x      = PC_W'(dp);
   assign arg_x     = PC_W'(instr_arg);
   assign tape_room = PC_W'(TAPE_DEPTH - 1) - dp_x;
   assign prog_room = prog_len - pc - PC_W'(1);
   assign cell_zero = (cur_cell == '0);

   always_comb begin
      res            = '0;
      res.status     = ST_OK;
      res.next_pc    = pc + PC_W'(1);
      res.dp_next    = dp;
      res.cell_wdata = cur_cell;

      if (prog_len == '0) begin
         res.status = ST_INVALID;
      end else if (pc >= prog_len) begin
         res.status = ST_TERMINATED;
      end else begin
         unique case (op)
            OP_PTR_INC: begin
               if (tape_room < arg_x) res.status = ST_SEGFAULT;
               else res.dp_next = DP_W'(dp_x + arg_x);
            end
            OP_PTR_DEC: begin
               if (arg_x > dp_x) res.status = ST_SEGFAULT;
               else res.dp_next = DP_W'(dp_x - arg_x);
            end
            OP_ADD: begin
               res.cell_we    = 1'b1;
               res.cell_wdata = cur_cell + instr_arg[BYTE_W-1:0];
            end
            OP_SUB: begin
               res.cell_we    = 1'b1;
               res.cell_wdata = cur_cell - instr_arg[BYTE_W-1:0];
            end
            OP_OUT: begin
               res.out_valid = 1'b1;
               res.out_byte  = cur_cell;
            end
            OP_IN: begin
               res.cell_we    = 1'b1;
               res.cell_wdata = input_byte;
            end
            OP_JFZ: begin
               if (prog_room < arg_x) res.status = ST_SEGFAULT;
               else if (cell_zero) res.next_pc = pc + arg_x;
            end
            OP_JBZ: begin
               if (arg_x > pc) res.status = ST_SEGFAULT;
               else if (cell_zero) res.next_pc = pc - arg_x;
            end
            default: res.status = ST_INVALID;
         endcase
      end

      // errors leave all state untouched
      if (res.status != ST_OK) begin
         res.next_pc   = pc;
         res.dp_next   = dp;
         res.cell_we   = 1'b0;
         res.out_valid = 1'b0;
         res.out_byte  = '0;
      end
   end

endmodule

// ===== rtl/tape_machine_instruction_executor.sv =====
// Top level of the tape machine instruction executor
`timescale 1ns / 1ps
`include "tape_machine_instruction_executor_macros.svh"

// Executes one byte-tape machine instruction per request beat and returns one
// response beat per instruction. The tape (4096 bytes) sits in a single-port-
// write, registered-read memory. After reset a clearing pass writes zero to
// every tape cell, one per cycle; req_ready stays low during that pass, while
// csr writes are taken at any time (csr_ready is always high). Pipeline: an
// accepted request beat is registered into the execute stage, executes there,
// and its response beat is registered into the output register. Sustained
// rate is one instruction per cycle while rsp_ready stays high: the tape is
// read every cycle at the data pointer that the instruction in the execute
// stage leaves behind, and a one-entry bypass covers a read that overlaps the
// write of that same instruction. The response sits in an output register, so
// a new request beat is accepted while an earlier response waits for
// rsp_ready. rsp_next_pc is the address of the next fetch; a caller that
// fetches from it waits for each response, whereas a caller that streams
// instructions ahead gets one per cycle while rsp_ready stays high. Writing
// program_length (saturated to 65536) sets the program counter to zero; it is
// meant to be written only while no instruction is in flight.
module tape_machine_instruction_executor (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tme_pkg::MODE_W-1:0]  req_mode,
   input  logic [tme_pkg::ARG_W-1:0]   req_instr_arg,
   input  logic [tme_pkg::BYTE_W-1:0]  req_input_byte,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [tme_pkg::PC_W-1:0]    rsp_next_pc,
   output logic                        rsp_out_valid,
   output logic [tme_pkg::BYTE_W-1:0]  rsp_out_byte,
   // configuration write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tme_pkg::LEN_W-1:0]   csr_program_length
);
   import tme_pkg::*;

   // architectural state
   logic [PC_W-1:0]   pc_ff, pc_ff_in;
   logic [DP_W-1:0]   dp_ff, dp_ff_in;
   logic [LEN_W-1:0]  len_ff, len_ff_in;

   // tape clearing pass after reset
   logic              clearing_ff, clearing_ff_in;
   logic [DP_W-1:0]   clr_addr_ff, clr_addr_ff_in;

   // execute stage
   logic                 exec_valid_ff, exec_valid_ff_in;
   logic [MODE_W-1:0]    exec_mode_ff;
   logic [ARG_W-1:0]     exec_arg_ff;
   logic [BYTE_W-1:0]    exec_inb_ff;

   // bypass for a read that hits the cell written in the same cycle
   logic                 byp_hit_ff;
   logic [BYTE_W-1:0]    byp_data_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_ff_in;
   status_type           rsp_status_ff;
   logic [PC_W-1:0]      rsp_next_pc_ff;
   logic                 rsp_out_valid_ff;
   logic [BYTE_W-1:0]    rsp_out_byte_ff;

   logic                 req_fire;
   logic                 csr_fire;
   logic                 exec_fire;
   logic [LEN_W-1:0]     csr_len_sat;
   logic [BYTE_W-1:0]    mem_rdata;
   logic [BYTE_W-1:0]    cur_cell;
   logic                 mem_we;
   logic [DP_W-1:0]      mem_waddr;
   logic [BYTE_W-1:0]    mem_wdata;
   exec_result_type      res;

   // handshakes
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign exec_fire = exec_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clearing_ff && (!exec_valid_ff || exec_fire);
   assign req_fire  = req_valid && req_ready;

   assign csr_len_sat = (csr_program_length > LEN_W'(PROG_DEPTH)) ?
                        LEN_W'(PROG_DEPTH) : csr_program_length;

   assign cur_cell = byp_hit_ff ? byp_data_ff : mem_rdata;

   tme_exec u_exec (
      .pc         (pc_ff),
      .dp         (dp_ff),
      .prog_len   (len_ff),
      .mode       (exec_mode_ff),
      .instr_arg  (exec_arg_ff),
      .input_byte (exec_inb_ff),
      .cur_cell   (cur_cell),
      .res        (res)
   );

   // tape write: clearing pass or executed instruction
   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = exec_fire && res.cell_we;
         mem_waddr = dp_ff;
         mem_wdata = res.cell_wdata;
      end
   end

   // read port always tracks the pointer the next instruction will use
   tme_tape_ram u_tape (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (dp_ff_in),
      .rdata (mem_rdata)
   );

   // next-state logic
   always_comb begin
      pc_ff_in         = pc_ff;
      dp_ff_in         = dp_ff;
      len_ff_in        = len_ff;
      clearing_ff_in   = clearing_ff;
      clr_addr_ff_in   = clr_addr_ff;
      exec_valid_ff_in = exec_valid_ff;
      rsp_valid_ff_in  = rsp_valid_ff;

      if (clearing_ff) begin
         clr_addr_ff_in = clr_addr_ff + DP_W'(1);
         if (clr_addr_ff == DP_W'(TAPE_DEPTH - 1)) clearing_ff_in = 1'b0;
      end

      if (exec_fire) begin
         pc_ff_in = res.next_pc;
         dp_ff_in = res.dp_next;
      end

      if (csr_fire) begin
         len_ff_in = csr_len_sat;
         pc_ff_in  = '0;
      end

      if (req_fire) exec_valid_ff_in = 1'b1;
      else if (exec_fire) exec_valid_ff_in = 1'b0;

      if (exec_fire) rsp_valid_ff_in = 1'b1;
      else if (rsp_ready) rsp_valid_ff_in = 1'b0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= '0;
         dp_ff         <= '0;
         len_ff        <= '0;
         clearing_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         exec_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         byp_hit_ff    <= 1'b0;
      end else begin
         pc_ff         <= pc_ff_in;
         dp_ff         <= dp_ff_in;
         len_ff        <= len_ff_in;
         clearing_ff   <= clearing_ff_in;
         clr_addr_ff   <= clr_addr_ff_in;
         exec_valid_ff <= exec_valid_ff_in;
         rsp_valid_ff  <= rsp_valid_ff_in;
         byp_hit_ff    <= mem_we && (mem_waddr == dp_ff_in);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byp_data_ff <= mem_wdata;
      if (req_fire) begin
         exec_mode_ff <= req_mode;
         exec_arg_ff  <= req_instr_arg;
         exec_inb_ff  <= req_input_byte;
      end
      if (exec_fire) begin
         rsp_status_ff    <= res.status;
         rsp_next_pc_ff   <= res.next_pc;
         rsp_out_valid_ff <= res.out_valid;
         rsp_out_byte_ff  <= res.out_byte;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_next_pc   = rsp_next_pc_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;

   // nothing executes while the tape is still being cleared
   `TME_ASSERT_NOW(a_no_exec_in_clear, clock, reset, clearing_ff, !exec_valid_ff,
      "instruction in execute stage during tape clearing")

   // an executed instruction always lands in the output register
   `TME_ASSERT_NEXT(a_exec_to_rsp, clock, reset, exec_fire, rsp_valid_ff,
      "executed instruction produced no response")

   // a failing instruction leaves pc and data pointer alone
   `TME_ASSERT_NEXT(a_err_no_change, clock, reset,
      exec_fire && !csr_fire && (res.status != ST_OK),
      $stable(pc_ff) && $stable(dp_ff),
      "error step changed pc or data pointer")

   // an emitted byte only comes with a good status
   `TME_ASSERT_NOW(a_out_needs_ok, clock, reset, rsp_valid_ff && rsp_out_valid_ff,
      rsp_status_ff == ST_OK, "output byte flagged on an error response")

endmodule

// ===== dv/tape_machine_instruction_executor_step_checker.sv =====
// Checker: watches the three channels, predicts each response beat and compares it
`timescale 1ns / 1ps

module tape_machine_instruction_executor_step_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [tme_pkg::MODE_W-1:0]  req_mode,
   input  logic [tme_pkg::ARG_W-1:0]   req_instr_arg,
   input  logic [tme_pkg::BYTE_W-1:0]  req_input_byte,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [1:0]                  rsp_status,
   input  logic [tme_pkg::PC_W-1:0]    rsp_next_pc,
   input  logic                        rsp_out_valid,
   input  logic [tme_pkg::BYTE_W-1:0]  rsp_out_byte,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [tme_pkg::LEN_W-1:0]   csr_program_length,
   output int unsigned                 fail_count,
   output int unsigned                 outstanding
);
   import tme_pkg::*;

   typedef struct packed {
      status_type          status;
      logic [PC_W-1:0]     next_pc;
      logic                out_valid;
      logic [BYTE_W-1:0]   out_byte;
   } step_outcome_type;

   // shadow machine state
   logic [LEN_W-1:0]  prog_len;
   logic [PC_W-1:0]   pc;
   logic [DP_W-1:0]   dp;
   logic [BYTE_W-1:0] tape [TAPE_DEPTH];

   step_outcome_type  pending_steps [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // Executes one instruction on the shadow state and queues its outcome.
   // Errors leave pc, dp and the tape untouched.
   task automatic execute_step(input logic [MODE_W-1:0] mode, input logic [ARG_W-1:0] arg,
                               input logic [BYTE_W-1:0] in_byte);
      step_outcome_type  res;
      logic [BYTE_W-1:0] cur_cell;
      logic [BYTE_W-1:0] cell_n;
      logic              cell_we;
      logic [DP_W-1:0]   dp_n;
      logic [PC_W-1:0]   pc_n;
      res.status    = ST_OK;
      res.next_pc   = pc;
      res.out_valid = 1'b0;
      res.out_byte  = '0;
      cur_cell = tape[dp];
      cell_n   = cur_cell;
      cell_we  = 1'b0;
      dp_n     = dp;
      pc_n     = pc + 1'b1;
      if (prog_len == '0) begin
         res.status = ST_INVALID;
      end else if (pc >= prog_len) begin
         res.status = ST_TERMINATED;
      end else begin
         case (mode)
            OP_PTR_INC: begin
               if (int'(arg) > TAPE_DEPTH - 1 - int'(dp)) res.status = ST_SEGFAULT;
               else dp_n = DP_W'(dp + arg);
            end
            OP_PTR_DEC: begin
               if (int'(arg) > int'(dp)) res.status = ST_SEGFAULT;
               else dp_n = DP_W'(dp - arg);
            end
            OP_ADD: begin
               cell_n  = cur_cell + arg[BYTE_W-1:0];
               cell_we = 1'b1;
            end
            OP_SUB: begin
               cell_n  = cur_cell - arg[BYTE_W-1:0];
               cell_we = 1'b1;
            end
            OP_OUT: begin
               res.out_valid = 1'b1;
               res.out_byte  = cur_cell;
            end
            OP_IN: begin
               cell_n  = in_byte;
               cell_we = 1'b1;
            end
            OP_JFZ: begin
               // range is checked whether or not the jump is taken
               if (int'(arg) > int'(prog_len) - int'(pc) - 1) res.status = ST_SEGFAULT;
               else if (cur_cell == '0) pc_n = pc + arg;
            end
            OP_JBZ: begin
               if (int'(arg) > int'(pc)) res.status = ST_SEGFAULT;
               else if (cur_cell == '0) pc_n = pc - arg;
            end
            default: res.status = ST_INVALID;
         endcase
      end
      if (res.status == ST_OK) begin
         if (cell_we) tape[dp] = cell_n;
         dp          = dp_n;
         pc          = pc_n;
         res.next_pc = pc_n;
      end else begin
         res.out_valid = 1'b0;
         res.out_byte  = '0;
      end
      pending_steps.push_back(res);
   endtask

   task automatic check_response();
      step_outcome_type want;
      if (pending_steps.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: response beat with nothing expected: status %0d next_pc %0d",
                     $time, rsp_status, rsp_next_pc);
         return;
      end
      want = pending_steps.pop_front();
      if (rsp_status !== want.status || rsp_next_pc !== want.next_pc ||
          rsp_out_valid !== want.out_valid || rsp_out_byte !== want.out_byte) begin
         fail_count++;
         if (fail_count <= 10)
            $display({"%0t: mismatch: expected status %0d next_pc %0d out %0b/%02h,",
                      " got status %0d next_pc %0d out %0b/%02h"}, $time,
                     want.status, want.next_pc, want.out_valid, want.out_byte,
                     rsp_status, rsp_next_pc, rsp_out_valid, rsp_out_byte);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         prog_len = '0;
         pc       = '0;
         dp       = '0;
         foreach (tape[i]) tape[i] = '0;
         pending_steps.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_response();
         if (csr_valid && csr_ready) begin
            prog_len = (csr_program_length > LEN_W'(PROG_DEPTH)) ? LEN_W'(PROG_DEPTH)
                                                                  : csr_program_length;
            pc       = '0;
         end
         if (req_valid && req_ready) execute_step(req_mode, req_instr_arg, req_input_byte);
      end
      outstanding <= pending_steps.size();
   end

endmodule

// ===== dv/tape_machine_instruction_executor_tb.sv =====
// Testbench top: clock, reset, stimulus and verdict for the tape machine executor
`timescale 1ns / 1ps

module tape_machine_instruction_executor_tb;
   import tme_pkg::*;

   // Slowest run: the tape clear, ~1250 beats with 7% gaps on both sides, one
   // hold-off of HOLD_OFF_CYCLES and a few drains. Well under CYCLE_LIMIT.
   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned NUM_PHASES      = 10;

   // opcodes outside the defined set
   localparam logic [MODE_W-1:0] OP_BAD_LO = 4'd8;
   localparam logic [MODE_W-1:0] OP_BAD_HI = 4'd15;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode;
   logic [ARG_W-1:0]    req_instr_arg;
   logic [BYTE_W-1:0]   req_input_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [1:0]          rsp_status;
   logic [PC_W-1:0]     rsp_next_pc;
   logic                rsp_out_valid;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                csr_valid;
   logic                csr_ready;
   logic [LEN_W-1:0]    csr_program_length;

   int unsigned         fail_count;
   int unsigned         outstanding;
   int unsigned         cycles;

   // quiet: neither side idles; choke: ask the response side for its long hold-off
   bit                  quiet;
   bit                  choke;

   // program length and beat count of each random phase
   int unsigned         phase_len   [NUM_PHASES];
   int unsigned         phase_beats [NUM_PHASES];

   tape_machine_instruction_executor dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_instr_arg      (req_instr_arg),
      .req_input_byte     (req_input_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_next_pc        (rsp_next_pc),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_out_byte       (rsp_out_byte),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_program_length (csr_program_length)
   );

   tape_machine_instruction_executor_step_checker step_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_instr_arg      (req_instr_arg),
      .req_input_byte     (req_input_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_next_pc        (rsp_next_pc),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_out_byte       (rsp_out_byte),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_program_length (csr_program_length),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends here.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[tape_machine_instruction_executor] ERROR");
         $finish;
      end
   end

   // Response side: ~7% random stalls, none while quiet, and one long
   // hold-off once choke is raised so the pipe fills and req_ready drops.
   initial begin : response_sink
      int unsigned held;
      held = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (choke && held < HOLD_OFF_CYCLES) begin
            held++;
            rsp_ready <= 1'b0;
         end else if (quiet) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 7);
         end
      end
   end

   // Offers one instruction beat, after an optional random gap, and returns
   // at the edge where it is taken. Valid stays high into the next beat unless
   // the caller or the next gap lowers it.
   task automatic send_instr(input logic [MODE_W-1:0] mode, input logic [ARG_W-1:0] arg,
                             input logic [BYTE_W-1:0] in_byte);
      while (!quiet && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_instr_arg  <= arg;
      req_input_byte <= in_byte;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering and waits until every predicted response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Length writes happen only with nothing in flight; each one restarts pc.
   task automatic write_length(input logic [LEN_W-1:0] len);
      wait_drained();
      csr_valid          <= 1'b1;
      csr_program_length <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [MODE_W-1:0] mode;
      logic [ARG_W-1:0]  arg;
      logic [BYTE_W-1:0] in_byte;
      int unsigned       sel;

      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_mode           <= '0;
      req_instr_arg      <= '0;
      req_input_byte     <= '0;
      csr_valid          <= 1'b0;
      csr_program_length <= '0;
      quiet = 1'b0;
      choke = 1'b0;

      // mostly full-size programs, plus short ones that run off the end,
      // the saturating length and one random length
      phase_len   = '{65536, 65536, 300, 17'h1FFFF, 30, 65536, 1, 2, 65536, 4000};
      phase_beats = '{100,   200,   120, 150,       40, 200,   150, 10, 150, 100};
      phase_len[6] = $urandom_range(65536, 1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // no program loaded yet: everything is rejected as invalid
      send_instr(OP_OUT, 16'd0, 8'd0);
      send_instr(OP_BAD_HI, 16'hFFFF, 8'hFF);

      write_length(17'd16);
      send_instr(OP_PTR_DEC, 16'd1, 8'd0);        // below cell 0
      send_instr(OP_PTR_INC, 16'hFFFF, 8'd0);     // far past the tape
      send_instr(OP_PTR_INC, 16'd4095, 8'd0);     // lands on the last cell
      send_instr(OP_BAD_LO, 16'd0, 8'd0);         // undefined opcode
      send_instr(OP_PTR_INC, 16'd1, 8'd0);        // one past the last cell
      send_instr(OP_ADD, 16'hFFFF, 8'd0);         // only the low byte counts
      send_instr(OP_OUT, 16'd0, 8'd0);
      send_instr(OP_PTR_DEC, 16'd4095, 8'd0);     // back to cell 0
      send_instr(OP_IN, 16'd0, 8'hA5);
      send_instr(OP_JFZ, 16'd3, 8'd0);            // cell nonzero: falls through
      send_instr(OP_JBZ, 16'hFFFF, 8'd0);         // out of range, cell nonzero
      send_instr(OP_JFZ, 16'hFFFF, 8'd0);
      send_instr(OP_SUB, 16'h01A5, 8'd0);         // only the low byte counts: cell drops to zero
      send_instr(OP_JBZ, 16'd0, 8'd0);            // jump in place
      send_instr(OP_JBZ, 16'd3, 8'd0);
      send_instr(OP_JFZ, 16'd11, 8'd0);           // exactly to the last instruction
      send_instr(OP_IN, 16'd0, 8'h5A);
      send_instr(OP_OUT, 16'd0, 8'd0);            // past the end

      write_length(17'd1);
      send_instr(OP_SUB, 16'd1, 8'd0);
      send_instr(OP_ADD, 16'd1, 8'd0);

      write_length(17'h1FFFF);                    // saturates to the full depth
      send_instr(OP_OUT, 16'd0, 8'd0);

      write_length(17'd0);
      send_instr(OP_IN, 16'd0, 8'hFF);

      // --- random part ---
      // Pointer moves and jumps mostly small so dp and pc wander without
      // constantly faulting; zero input bytes keep cells at zero for jumps.
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_length(LEN_W'(phase_len[p]));
         quiet = (p == 1);
         for (int i = 0; i < int'(phase_beats[p]); i++) begin
            if (p == 5 && i == 40) choke = 1'b1;
            if ($urandom_range(99) < 6) mode = MODE_W'($urandom_range(OP_BAD_HI, OP_BAD_LO));
            else mode = MODE_W'($urandom_range(OP_JBZ, OP_PTR_INC));
            case (mode) inside
               OP_PTR_INC, OP_PTR_DEC: begin
                  sel = $urandom_range(99);
                  if (sel < 80) arg = ARG_W'($urandom_range(40));
                  else if (sel < 90) arg = ARG_W'($urandom_range(TAPE_DEPTH - 1));
                  else arg = ARG_W'($urandom_range(16'hFFFF));
               end
               OP_JFZ, OP_JBZ: begin
                  if ($urandom_range(99) < 85) arg = ARG_W'($urandom_range(6));
                  else arg = ARG_W'($urandom_range(16'hFFFF));
               end
               default: arg = ARG_W'($urandom_range(16'hFFFF));
            endcase
            if ($urandom_range(99) < 20) in_byte = '0;
            else in_byte = BYTE_W'($urandom_range(255));
            send_instr(mode, arg, in_byte);
         end
         quiet = 1'b0;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("[tape_machine_instruction_executor] OK");
      end else begin
         $display("[tape_machine_instruction_executor] ERROR");
      end
      $finish;
   end

endmodule
